/* rtl/csvtok_pkg.sv */
// Shared constants and types of the CSV field tokenizer.
package csvtok_pkg;

    // Default counter widths.
    localparam int ROW_BITS_DEF    = 32;
    localparam int COLUMN_BITS_DEF = 16;

    // Widths of the reported row and column numbers.
    localparam int ROW_OUT_W = 32;
    localparam int COL_OUT_W = 16;

    // Result buffer depth; one input byte causes at most two results.
    localparam int MAX_RES = 3;
    localparam int RES_IDX_W = 2;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Register reset values.
    localparam logic [7:0]  SEPARATOR_RST = 8'd59;
    localparam logic [7:0]  QUOTE_RST     = 8'd34;
    localparam logic [31:0] LAST_ROW_RST  = 32'hFFFF_FFFF;

    // Fixed characters.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEPARATOR  = 3'd0,
        CFG_QUOTE      = 3'd1,
        CFG_MERGE_SEP  = 3'd2,
        CFG_QUOTED_STR = 3'd3,
        CFG_FIRST_ROW  = 3'd4,
        CFG_LAST_ROW   = 3'd5
    } cfg_index_t;

    // One result item without its row and column number.
    typedef struct packed {
        logic       is_string;
        logic       record_end;
        logic       field_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } res_entry_t;

endpackage

/* rtl/csv_field_tokenizer_top.sv */
// CSV field tokenizer: splits and cleans CSV text, one byte per transfer.
//
// The block takes one byte of CSV text per cycle while s_tready is high.
// Each accepted byte updates the parser state and produces zero to two
// result items (a field byte or a field end, either one possibly preceded
// by a pending blank), which are loaded into a three-entry result buffer
// and handed out one per output transfer. A byte is taken whenever the
// buffer is empty or its last entry leaves in the same cycle, so text that
// yields at most one result per byte streams at one byte per cycle while
// the output is ready; a byte yielding more results holds the input until
// its last result leaves. Rows outside the first_row..last_row window are
// parsed but yield nothing. The end-of-text flag (tlast) flushes the
// pending field and record; its data byte is ignored.
module csv_field_tokenizer_top
    import csvtok_pkg::*;
#(
    parameter int ROW_BITS    = ROW_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input text stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // in_byte
    input  logic                   s_tlast,   // end_of_text
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [55:0]            m_tdata,   // out_byte, row_number, column_number
    output logic [3:0]             m_tuser,   // byte_valid, field_end, record_end,
                                              // field_is_string
    output logic                   m_tlast    // last_of_run
);

    localparam int ROW_CMP_W = (ROW_BITS > ROW_OUT_W) ? ROW_BITS : ROW_OUT_W;
    localparam int COL_CMP_W = (COLUMN_BITS > COL_OUT_W) ? COLUMN_BITS : COL_OUT_W;

    // Configuration registers.
    logic [7:0]  separator_reg;
    logic [7:0]  quote_reg;
    logic        merge_sep_reg;
    logic        quoted_str_reg;
    logic [31:0] first_row_reg;
    logic [31:0] last_row_reg;

    // Parser state.
    logic [ROW_BITS-1:0]    row_count_reg, row_count_next;
    logic [COLUMN_BITS-1:0] col_count_reg, col_count_next;
    logic in_quotes_reg, in_quotes_next;
    logic in_field_reg, in_field_next;
    logic after_cr_reg, after_cr_next;
    logic after_sep_reg, after_sep_next;
    logic pending_sp_reg, pending_sp_next;
    logic held_quote_reg, held_quote_next;
    logic field_quoted_reg, field_quoted_next;
    logic rec_nonempty_reg, rec_nonempty_next;

    // Results of the current byte.
    res_entry_t           res_v [MAX_RES];
    logic [RES_IDX_W-1:0] res_n;
    logic                 in_window;

    // Result buffer.
    res_entry_t           buf_reg [MAX_RES];
    logic [ROW_OUT_W-1:0] buf_row_reg;
    logic [COL_OUT_W-1:0] buf_col_reg;
    logic [RES_IDX_W-1:0] rem_reg;
    logic [RES_IDX_W-1:0] rd_idx_reg;

    logic s_xfer;
    logic m_xfer;
    logic [ROW_CMP_W-1:0] row_cmp;
    logic [COL_CMP_W-1:0] col_cmp;

    // Handshakes: take a byte once the buffer empties or drains this cycle.
    assign s_tready = (rem_reg == '0) || ((rem_reg == RES_IDX_W'(1)) && m_tready);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = (rem_reg != '0);
    assign m_xfer   = m_tvalid && m_tready;

    // Row window test on the current row.
    assign row_cmp   = ROW_CMP_W'(row_count_reg);
    assign col_cmp   = COL_CMP_W'(col_count_reg);
    assign in_window = !(row_cmp < ROW_CMP_W'(first_row_reg))
                    && !(row_cmp > ROW_CMP_W'(last_row_reg));

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            separator_reg  <= SEPARATOR_RST;
            quote_reg      <= QUOTE_RST;
            merge_sep_reg  <= 1'b0;
            quoted_str_reg <= 1'b1;
            first_row_reg  <= '0;
            last_row_reg   <= LAST_ROW_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_SEPARATOR:  separator_reg  <= cfg_wdata[7:0];
                CFG_QUOTE:      quote_reg      <= cfg_wdata[7:0];
                CFG_MERGE_SEP:  merge_sep_reg  <= cfg_wdata[0];
                CFG_QUOTED_STR: quoted_str_reg <= cfg_wdata[0];
                CFG_FIRST_ROW:  first_row_reg  <= cfg_wdata[31:0];
                CFG_LAST_ROW:   last_row_reg   <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Parser step: next state and the result list for one input byte.
    always_comb begin
        logic [7:0] b;
        logic       blank;
        logic       done;
        logic       close_field;
        logic       close_rec;

        b     = s_tdata;
        blank = (b == CH_SP) || (b == CH_TAB);
        done  = 1'b0;
        close_field = 1'b0;
        close_rec   = 1'b0;

        row_count_next    = row_count_reg;
        col_count_next    = col_count_reg;
        in_quotes_next    = in_quotes_reg;
        in_field_next     = in_field_reg;
        after_cr_next     = after_cr_reg;
        after_sep_next    = after_sep_reg;
        pending_sp_next   = pending_sp_reg;
        held_quote_next   = held_quote_reg;
        field_quoted_next = field_quoted_reg;
        rec_nonempty_next = rec_nonempty_reg;

        res_n = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_v[i] = '0;
        end

        if (s_tlast) begin
            // End of text: close a held quote, flush the open record.
            if (held_quote_reg) begin
                held_quote_next = 1'b0;
                if (pending_sp_next) begin
                    res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, CH_SP};
                    res_n = res_n + 1'b1;
                    pending_sp_next = 1'b0;
                end
            end
            after_cr_next  = 1'b0;
            after_sep_next = 1'b0;
            if (rec_nonempty_next) begin
                close_field = 1'b1;
                close_rec   = 1'b1;
            end
            in_quotes_next = 1'b0;
            done = 1'b1;
        end

        // Swallow LF or further CR after a CR.
        if (!done && after_cr_next) begin
            if (b == CH_CR) begin
                done = 1'b1;
            end else begin
                after_cr_next = 1'b0;
                if (b == CH_LF) begin
                    done = 1'b1;
                end
            end
        end

        // A quote held inside delimited text: doubled quote or closing quote.
        if (!done && held_quote_next) begin
            held_quote_next = 1'b0;
            if (pending_sp_next) begin
                res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, CH_SP};
                res_n = res_n + 1'b1;
                pending_sp_next = 1'b0;
            end
            if (b == quote_reg) begin
                in_quotes_next = 1'b1;
                res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, b};
                res_n = res_n + 1'b1;
                done = 1'b1;
            end
        end

        if (!done) begin
            if (in_quotes_next) begin
                // Inside delimited text everything but the quote is data.
                rec_nonempty_next = 1'b1;
                after_sep_next    = 1'b0;
                if (b == quote_reg) begin
                    held_quote_next = 1'b1;
                    in_quotes_next  = 1'b0;
                end else if (blank) begin
                    pending_sp_next = 1'b1;
                end else begin
                    if (pending_sp_next) begin
                        res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, CH_SP};
                        res_n = res_n + 1'b1;
                        pending_sp_next = 1'b0;
                    end
                    res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, b};
                    res_n = res_n + 1'b1;
                end
            end else if ((b == CH_CR) || (b == CH_LF)) begin
                // Line end closes a record that holds any byte.
                after_sep_next = 1'b0;
                if (rec_nonempty_next) begin
                    close_field = 1'b1;
                    close_rec   = 1'b1;
                end
                after_cr_next = (b == CH_CR);
            end else begin
                rec_nonempty_next = 1'b1;
                if (b == separator_reg) begin
                    if (!(merge_sep_reg && after_sep_next)) begin
                        close_field    = 1'b1;
                        after_sep_next = 1'b1;
                    end
                end else begin
                    after_sep_next = 1'b0;
                    if ((b == quote_reg) && !in_field_next) begin
                        in_field_next     = 1'b1;
                        field_quoted_next = 1'b1;
                        in_quotes_next    = 1'b1;
                    end else if (blank) begin
                        if (in_field_next) begin
                            pending_sp_next = 1'b1;
                        end
                    end else begin
                        if (pending_sp_next) begin
                            res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, CH_SP};
                            res_n = res_n + 1'b1;
                            pending_sp_next = 1'b0;
                        end
                        res_v[res_n] = '{1'b0, 1'b0, 1'b0, 1'b1, b};
                        res_n = res_n + 1'b1;
                        in_field_next = 1'b1;
                    end
                end
            end
        end

        // Field end result and counter updates.
        if (close_field) begin
            res_v[res_n] = '{field_quoted_next && quoted_str_reg, close_rec, 1'b1,
                             1'b0, 8'h00};
            res_n = res_n + 1'b1;
            in_field_next     = 1'b0;
            field_quoted_next = 1'b0;
            pending_sp_next   = 1'b0;
            in_quotes_next    = 1'b0;
            held_quote_next   = 1'b0;
            if (close_rec) begin
                if (row_count_reg != '1) begin
                    row_count_next = row_count_reg + ROW_BITS'(1);
                end
                col_count_next    = '0;
                rec_nonempty_next = 1'b0;
            end else if (col_count_reg != '1) begin
                col_count_next = col_count_reg + COLUMN_BITS'(1);
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            in_quotes_reg    <= 1'b0;
            in_field_reg     <= 1'b0;
            after_cr_reg     <= 1'b0;
            after_sep_reg    <= 1'b0;
            pending_sp_reg   <= 1'b0;
            held_quote_reg   <= 1'b0;
            field_quoted_reg <= 1'b0;
            rec_nonempty_reg <= 1'b0;
        end else if (s_xfer) begin
            row_count_reg    <= row_count_next;
            col_count_reg    <= col_count_next;
            in_quotes_reg    <= in_quotes_next;
            in_field_reg     <= in_field_next;
            after_cr_reg     <= after_cr_next;
            after_sep_reg    <= after_sep_next;
            pending_sp_reg   <= pending_sp_next;
            held_quote_reg   <= held_quote_next;
            field_quoted_reg <= field_quoted_next;
            rec_nonempty_reg <= rec_nonempty_next;
        end
    end

    // Result buffer control: load on a transfer in, step on a transfer out.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg    <= '0;
            rd_idx_reg <= '0;
        end else if (s_xfer && in_window && (res_n != '0)) begin
            rem_reg    <= res_n;
            rd_idx_reg <= '0;
        end else if (m_xfer) begin
            rem_reg    <= rem_reg - 1'b1;
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    // Result buffer payload.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int i = 0; i < MAX_RES; i++) begin
                buf_reg[i] <= res_v[i];
            end
            buf_row_reg <= row_cmp[ROW_OUT_W-1:0];
            buf_col_reg <= col_cmp[COL_OUT_W-1:0];
        end
    end

    // Output packing.
    assign m_tdata = {buf_col_reg, buf_row_reg, buf_reg[rd_idx_reg].out_byte};
    assign m_tuser = {buf_reg[rd_idx_reg].is_string, buf_reg[rd_idx_reg].record_end,
                      buf_reg[rd_idx_reg].field_end, buf_reg[rd_idx_reg].byte_valid};
    assign m_tlast = (rem_reg == RES_IDX_W'(1));

endmodule
